// ===== hdl/tant_pkg.sv =====
`timescale 1ns / 1ps
package tant_pkg;

	localparam int NCOEF = 14;
	localparam int NUNIT = NCOEF + 1;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SAT_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// odd Taylor coefficients of tan, unsigned Q3.61, C1 first
	localparam logic [63:0] COEF [NCOEF] = '{
		64'h2000000000000000,
		64'h0aaaaaaaaaaaaaab,
		64'h0444444444444444,
		64'h01ba1ba1ba1ba1ba,
		64'h00b327a4416087d0,
		64'h00489b8d579b08f2,
		64'h001d6d3d0e157de0,
		64'h000bed1b2295baf1,
		64'h0004d5609200d9d1,
		64'h0001f57d7734d166,
		64'h0000cb3f0c57e57d,
		64'h0000525f63ba8949,
		64'h0000216265a734c1,
		64'h00000d87b969f712
	};

	typedef struct packed {
		logic [63:0] mag;
		logic [63:0] x2;
		logic        neg;
		logic        last;
	} side_t;

endpackage

// ===== hdl/tant_msa.sv =====
`timescale 1ns / 1ps
module tant_msa (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            sh63,
	input  logic [63:0]     a,
	input  logic [63:0]     b,
	input  logic [63:0]     addend,
	input  logic            vld_in,
	input  tant_pkg::side_t side_in,
	output logic            vld_out,
	output tant_pkg::side_t side_out,
	output logic [63:0]     res
);
	import tant_pkg::*;

	logic [63:0]  pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic         vld_s1, vld_s2, vld_s3;
	side_t        side_s1, side_s2, side_s3;
	logic [127:0] prod_s2;
	logic [63:0]  res_s3;

	logic [64:0]  mid;
	logic [127:0] rnd;
	logic [127:0] prod;
	logic         ovf;
	logic [63:0]  shv;
	logic [63:0]  mq;
	logic [64:0]  sum;
	logic [63:0]  nxt;

	// (a*b + half) >> s, saturated, then + addend, saturated
	always_comb begin
		mid  = {1'b0, pp_lh_s1} + {1'b0, pp_hl_s1};
		rnd  = sh63 ? (128'd1 << 62) : (128'd1 << 60);
		prod = {pp_hh_s1, pp_ll_s1} + {31'd0, mid, 32'd0} + rnd;
	end

	always_comb begin
		if (sh63) begin
			ovf = prod_s2[127];
			shv = prod_s2[126:63];
		end else begin
			ovf = |prod_s2[127:125];
			shv = prod_s2[124:61];
		end
		mq  = ovf ? SAT_ONES : shv;
		sum = {1'b0, mq} + {1'b0, addend};
		nxt = sum[64] ? SAT_ONES : sum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a[31:0] * b[31:0];
			pp_lh_s1 <= a[31:0] * b[63:32];
			pp_hl_s1 <= a[63:32] * b[31:0];
			pp_hh_s1 <= a[63:32] * b[63:32];
			side_s1  <= side_in;
			prod_s2  <= prod;
			side_s2  <= side_s1;
			res_s3   <= nxt;
			side_s3  <= side_s2;
		end
	end

	assign vld_out  = vld_s3;
	assign side_out = side_s3;
	assign res      = res_s3;

endmodule

// ===== hdl/tan_taylor_polynomial_core.sv =====
`timescale 1ns / 1ps
// channel  | valid          | ready          | payload
// ---------+----------------+----------------+------------------
// request  | angle_valid    | angle_ready    | angle, last_in
// result   | tangent_valid  | tangent_ready  | tangent, last_out
//
// One request per cycle sustained while tangent_ready does not stall the output; the
// pipe is an input stage, fifteen three-stage 64x64 multiply units and an output register.
// All stages move together on one enable; the output register holds a result
// until taken, and the pipe advances whenever it is empty or being read.
// Reset clears the valid bits only.
module tan_taylor_polynomial_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        angle_valid,
	output logic        angle_ready,
	input  logic [63:0] angle,
	input  logic        last_in,
	output logic        tangent_valid,
	input  logic        tangent_ready,
	output logic [63:0] tangent,
	output logic        last_out
);
	import tant_pkg::*;

	logic        en;
	logic        vld_s1;
	side_t       side_s1;
	logic        tangent_valid_q;
	logic [63:0] tangent_q;
	logic        last_out_q;

	logic [63:0] a_in    [NUNIT];
	logic [63:0] b_in    [NUNIT];
	logic [63:0] add_in  [NUNIT];
	logic        sh_in   [NUNIT];
	logic        vld_in  [NUNIT];
	side_t       side_in [NUNIT];
	logic        vld_o   [NUNIT];
	side_t       side_o  [NUNIT];
	logic [63:0] res     [NUNIT];

	logic [63:0] rmag;
	logic [63:0] fin;

	assign en          = !tangent_valid_q || tangent_ready;
	assign angle_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= angle_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.mag  <= angle[63] ? (64'd0 - angle) : angle;
			side_s1.x2   <= 64'd0;
			side_s1.neg  <= angle[63];
			side_s1.last <= last_in;
		end
	end

	// unit 0: x^2; units 1..13: Horner steps; unit 14: final x*p
	for (genvar j = 0; j < NUNIT; j++) begin : g_unit
		if (j == 0) begin : g_sq
			assign a_in[j]    = side_s1.mag;
			assign b_in[j]    = side_s1.mag;
			assign add_in[j]  = 64'd0;
			assign sh_in[j]   = 1'b1;
			assign vld_in[j]  = vld_s1;
			assign side_in[j] = side_s1;
		end else if (j == 1) begin : g_first
			assign a_in[j]    = COEF[NCOEF-1];
			assign b_in[j]    = res[0];
			assign add_in[j]  = COEF[NCOEF-2];
			assign sh_in[j]   = 1'b0;
			assign vld_in[j]  = vld_o[0];
			assign side_in[j] = '{mag: side_o[0].mag, x2: res[0],
				neg: side_o[0].neg, last: side_o[0].last};
		end else if (j < NCOEF) begin : g_horner
			assign a_in[j]    = res[j-1];
			assign b_in[j]    = side_o[j-1].x2;
			assign add_in[j]  = COEF[NCOEF-1-j];
			assign sh_in[j]   = 1'b0;
			assign vld_in[j]  = vld_o[j-1];
			assign side_in[j] = side_o[j-1];
		end else begin : g_final
			assign a_in[j]    = side_o[j-1].mag;
			assign b_in[j]    = res[j-1];
			assign add_in[j]  = 64'd0;
			assign sh_in[j]   = 1'b0;
			assign vld_in[j]  = vld_o[j-1];
			assign side_in[j] = side_o[j-1];
		end

		tant_msa u_msa (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.sh63     (sh_in[j]),
			.a        (a_in[j]),
			.b        (b_in[j]),
			.addend   (add_in[j]),
			.vld_in   (vld_in[j]),
			.side_in  (side_in[j]),
			.vld_out  (vld_o[j]),
			.side_out (side_o[j]),
			.res      (res[j])
		);
	end

	always_comb begin
		rmag = res[NUNIT-1];
		if (side_o[NUNIT-1].neg) begin
			fin = rmag[63] ? NEG_MIN : (64'd0 - rmag);
		end else begin
			fin = rmag[63] ? POS_MAX : rmag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tangent_valid_q <= 1'b0;
		end else if (en) begin
			tangent_valid_q <= vld_o[NUNIT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tangent_q  <= fin;
			last_out_q <= side_o[NUNIT-1].last;
		end
	end

	assign tangent_valid = tangent_valid_q;
	assign tangent       = tangent_q;
	assign last_out      = last_out_q;

	a_x2_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o[0] |-> res[0] <= 64'h8000_0000_0000_0000)
		else $error("x2 above 4.0");

	a_poly_ge_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_o[NCOEF-1] |-> res[NCOEF-1] >= COEF[0])
		else $error("polynomial below 1.0");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_o[NUNIT-1] |=>
			(tangent[63] == $past(side_o[NUNIT-1].neg)) || (tangent == 64'd0))
		else $error("result sign mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_o[NUNIT-1]) && $stable(res[NUNIT-1]))
		else $error("pipe moved while stalled");

endmodule
